// ===== rtl/core/gcs_pkg.sv =====
// Package for the greedy coverage selector.
// Holds the payload structs, the controller command and status structs and shared constants.
// No dependencies.
package gcs_pkg;

    localparam int ONE_Q16 = 65536;
    localparam int WEIGHT_W = 17;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    localparam logic REG_POPULATION = 1'b0;
    localparam logic REG_SELECT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [16:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  rank;
        logic [5:0]  selected_index;
        logic [22:0] objective;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic clr_wr;
        logic load_first;
        logic load_second;
        logic run_init;
        logic cand_start;
        logic cand_next;
        logic issue;
        logic judge;
        logic pick;
        logic round_adv;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic count_zero;
        logic cand_marked;
        logic cand_last;
        logic issue_last;
        logic pipe_empty;
        logic round_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/gcs_ctrl.sv =====
// Controller state machine of the greedy coverage selector.
// Sequences the clearing pass, weight loads and the greedy rounds; uses gcs_pkg.
module gcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    input  gcs_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output gcs_pkg::t_cmd o_cmd
);

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b000000000001,
        ST_IDLE   = 12'b000000000010,
        ST_LOAD   = 12'b000000000100,
        ST_RUN    = 12'b000000001000,
        ST_CAND   = 12'b000000010000,
        ST_SWEEP  = 12'b000000100000,
        ST_DRAIN  = 12'b000001000000,
        ST_JUDGE  = 12'b000010000000,
        ST_PICK   = 12'b000100000000,
        ST_UPD    = 12'b001000000000,
        ST_UDRAIN = 12'b010000000000,
        ST_SPARE  = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == gcs_pkg::KIND_LOAD) begin
                        o_cmd.load_first = 1'b1;
                        n_state = ST_LOAD;
                    end else begin
                        o_cmd.run_init = 1'b1;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_second = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RUN: begin
                n_state = i_sts.count_zero ? ST_IDLE : ST_CAND;
            end
            ST_CAND: begin
                if (i_sts.cand_marked) begin
                    if (i_sts.cand_last) begin
                        n_state = ST_PICK;
                    end else begin
                        o_cmd.cand_next = 1'b1;
                    end
                end else begin
                    o_cmd.cand_start = 1'b1;
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                o_cmd.judge = 1'b1;
                if (i_sts.cand_last) begin
                    n_state = ST_PICK;
                end else begin
                    o_cmd.cand_next = 1'b1;
                    n_state = ST_CAND;
                end
            end
            ST_PICK: begin
                if (i_sts.out_free) begin
                    o_cmd.pick = 1'b1;
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = ST_UDRAIN;
                end
            end
            ST_UDRAIN: begin
                if (i_sts.pipe_empty) begin
                    o_cmd.round_adv = 1'b1;
                    n_state = i_sts.round_last ? ST_IDLE : ST_CAND;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/gcs_datapath.sv =====
// Datapath of the greedy coverage selector.
// Holds the weight memory, the running product memory, the multiply pipeline and the result register.
// Uses gcs_pkg; driven by gcs_ctrl through command and status structs.
module gcs_datapath #(
    parameter int MAX_INDIVIDUALS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gcs_pkg::t_cmd     i_cmd,
    input  gcs_pkg::t_in_item i_in_data,
    input  logic [6:0]        i_population_size,
    input  logic [6:0]        i_select_count,
    input  logic              i_out_ready,
    output gcs_pkg::t_sts     o_sts,
    output logic              o_out_valid,
    output gcs_pkg::t_out_item o_out_data
);

    localparam int IDX_W = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
    localparam int CNT_W = $clog2(MAX_INDIVIDUALS + 1);
    localparam int DEPTH = MAX_INDIVIDUALS * MAX_INDIVIDUALS;
    localparam int AW = $clog2(DEPTH);
    localparam int SUM_W = $clog2(MAX_INDIVIDUALS * gcs_pkg::ONE_Q16 + 1);
    localparam int WW = gcs_pkg::WEIGHT_W;

    logic [WW-1:0] r_wmem [DEPTH];
    logic [WW-1:0] r_pmem [MAX_INDIVIDUALS];

    logic [AW-1:0]    r_clr;
    logic [IDX_W-1:0] r_ld_row;
    logic [IDX_W-1:0] r_ld_col;
    logic [WW-1:0]    r_ld_w;
    logic             r_ld_ok;

    logic [CNT_W-1:0] r_pop;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rank;
    logic [IDX_W-1:0] r_cand;
    logic [IDX_W-1:0] r_i;
    logic             r_mode_upd;
    logic [MAX_INDIVIDUALS-1:0] r_mark;

    logic             r_s1_valid;
    logic             r_s1_skip;
    logic [IDX_W-1:0] r_s1_i;
    logic [WW-1:0]    r_w_rd;
    logic [WW-1:0]    r_p_rd;
    logic             r_s2_valid;
    logic             r_s2_skip;
    logic [IDX_W-1:0] r_s2_i;
    logic [WW-1:0]    r_s2_prod;

    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] r_best_val;
    logic [IDX_W-1:0] r_best_idx;
    logic             r_have;

    logic              r_out_valid;
    gcs_pkg::t_out_item r_out;

    logic             ld_ok;
    logic [AW-1:0]    ld_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WW-1:0]    wr_data;
    logic [WW-1:0]    ld_w;
    logic [IDX_W-1:0] rd_row;
    logic [AW-1:0]    rd_addr;
    logic [WW-1:0]    mul_src;
    logic [WW-1:0]    mul_fac;
    logic [2*WW-1:0]  mul_full;
    logic             out_free;

    assign ld_ok = (32'(i_in_data.row) < MAX_INDIVIDUALS) &&
                   (32'(i_in_data.col) < MAX_INDIVIDUALS);
    assign ld_addr = AW'(AW'(i_in_data.row) * AW'(MAX_INDIVIDUALS) + AW'(i_in_data.col));
    assign ld_w = (32'(i_in_data.weight) > gcs_pkg::ONE_Q16) ? WW'(gcs_pkg::ONE_Q16)
                                                             : i_in_data.weight;

    always_comb begin
        wr_en = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.load_first) begin
            wr_en = ld_ok;
            wr_addr = ld_addr;
            wr_data = ld_w;
        end else if (i_cmd.load_second) begin
            wr_en = r_ld_ok;
            wr_addr = AW'(AW'(r_ld_col) * AW'(MAX_INDIVIDUALS) + AW'(r_ld_row));
            wr_data = r_ld_w;
        end
    end

    assign rd_row = r_mode_upd ? r_best_idx : r_cand;
    assign rd_addr = AW'(AW'(rd_row) * AW'(MAX_INDIVIDUALS) + AW'(r_i));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wmem[wr_addr] <= wr_data;
        end
        r_w_rd <= r_wmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_mode_upd) begin
            r_pmem[r_s2_i] <= r_s2_prod;
        end
        r_p_rd <= r_pmem[r_i];
    end

    assign mul_src = (r_rank == '0) ? WW'(gcs_pkg::ONE_Q16) : r_p_rd;
    assign mul_fac = WW'(gcs_pkg::ONE_Q16) - r_w_rd;
    assign mul_full = mul_src * mul_fac;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first) begin
            r_ld_row <= IDX_W'(i_in_data.row);
            r_ld_col <= IDX_W'(i_in_data.col);
            r_ld_w <= ld_w;
        end
        r_s1_skip <= r_mark[r_i] || (!r_mode_upd && (r_i == r_cand));
        r_s1_i <= r_i;
        r_s2_skip <= r_s1_skip;
        r_s2_i <= r_s1_i;
        r_s2_prod <= mul_full[2*WW-2:WW-1];
        if (i_cmd.pick) begin
            r_out.rank <= 6'(r_rank);
            r_out.selected_index <= 6'(r_best_idx);
            r_out.objective <= 23'(r_best_val);
            r_out.last <= (r_rank + CNT_W'(1)) == r_count;
        end
        if (i_cmd.run_init) begin
            r_pop <= (32'(i_population_size) > MAX_INDIVIDUALS) ? CNT_W'(MAX_INDIVIDUALS)
                                                               : CNT_W'(i_population_size);
            if ((32'(i_select_count) > 32'(i_population_size)) ||
                (32'(i_select_count) > MAX_INDIVIDUALS)) begin
                r_count <= (32'(i_population_size) > MAX_INDIVIDUALS)
                           ? CNT_W'(MAX_INDIVIDUALS) : CNT_W'(i_population_size);
            end else begin
                r_count <= CNT_W'(i_select_count);
            end
        end
        if (i_cmd.cand_start) begin
            r_acc <= '0;
        end else if (r_s2_valid && !r_s2_skip) begin
            r_acc <= r_acc + SUM_W'(r_s2_prod);
        end
        if (i_cmd.judge && (!r_have || (r_acc < r_best_val))) begin
            r_best_val <= r_acc;
            r_best_idx <= r_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_ld_ok <= 1'b0;
            r_rank <= '0;
            r_cand <= '0;
            r_i <= '0;
            r_mode_upd <= 1'b0;
            r_mark <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_have <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load_first) begin
                r_ld_ok <= ld_ok;
            end
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            if (i_cmd.issue) begin
                r_i <= r_i + IDX_W'(1);
            end
            if (i_cmd.run_init) begin
                r_mark <= '0;
                r_rank <= '0;
                r_cand <= '0;
                r_have <= 1'b0;
            end
            if (i_cmd.cand_next) begin
                r_cand <= r_cand + IDX_W'(1);
            end
            if (i_cmd.cand_start) begin
                r_i <= '0;
                r_mode_upd <= 1'b0;
            end
            if (i_cmd.judge) begin
                r_have <= 1'b1;
            end
            if (i_cmd.pick) begin
                r_i <= '0;
                r_mode_upd <= 1'b1;
                r_mark[r_best_idx] <= 1'b1;
            end
            if (i_cmd.round_adv) begin
                r_rank <= r_rank + CNT_W'(1);
                r_cand <= '0;
                r_have <= 1'b0;
            end
            if (i_cmd.pick) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.clr_done = (r_clr == AW'(DEPTH - 1));
        o_sts.count_zero = (r_count == '0);
        o_sts.cand_marked = r_mark[r_cand];
        o_sts.cand_last = (CNT_W'(r_cand) == (r_pop - CNT_W'(1)));
        o_sts.issue_last = (CNT_W'(r_i) == (r_pop - CNT_W'(1)));
        o_sts.pipe_empty = !r_s1_valid && !r_s2_valid;
        o_sts.round_last = ((r_rank + CNT_W'(1)) == r_count);
        o_sts.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

// ===== rtl/core/greedy_coverage_selector.sv =====
// Greedy coverage selector. A weight load writes the weight and then its mirrored entry; a run
// item latches the population size and select count, then each round is paced by the single
// weight memory read port, which serves one individual per cycle for each candidate and for the
// product update. A pick also waits while the previous result is held.
// After reset a clearing pass zeroes all MAX_INDIVIDUALS squared weights, one a cycle (4096
// by default), before the first item is accepted. Uses gcs_pkg, gcs_ctrl and gcs_datapath.
module greedy_coverage_selector #(
    parameter int MAX_INDIVIDUALS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gcs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gcs_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    gcs_pkg::t_cmd cmd;
    gcs_pkg::t_sts sts;
    logic [6:0] r_population_size;
    logic [6:0] r_select_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_population_size <= 7'd64;
            r_select_count <= 7'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == gcs_pkg::REG_POPULATION) begin
                r_population_size <= pwdata[6:0];
            end else begin
                r_select_count <= pwdata[6:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == gcs_pkg::REG_SELECT) ? {25'd0, r_select_count}
                                                     : {25'd0, r_population_size};

    gcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gcs_datapath #(
        .MAX_INDIVIDUALS (MAX_INDIVIDUALS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_in_data         (i_in_data),
        .i_population_size (r_population_size),
        .i_select_count    (r_select_count),
        .i_out_ready       (i_out_ready),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .o_out_data        (o_out_data)
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> sts.pipe_empty)
        else $error("input accepted while the datapath pipeline is busy");

    a_pick_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pick |-> sts.out_free)
        else $error("result register overwritten before its transfer");

    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input accepted before the clearing pass");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !(cmd.pick || cmd.judge || cmd.run_init))
        else $error("conflicting datapath commands");

endmodule
